// File: src/assert_macros.svh
// Assertion macros for the blocklist RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with synchronous reset disable.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Clocked invariant.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`endif

// File: src/ecsb_pkg.sv
// Package: types and constants of the error-count source blocklist.
package ecsb_pkg;
  localparam int TableEntries = 64;
  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int QDepth = 2;

  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpClose = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;

  localparam logic [1:0] ActPass  = 2'd0;
  localparam logic [1:0] ActDown  = 2'd1;
  localparam logic [1:0] ActShut  = 2'd2;

  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegLimit  = 2'd1;
  localparam logic [1:0] RegPeriods = 2'd2;
  localparam logic [1:0] RegMode   = 2'd3;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_START,
    CMD_CLOSE,
    CMD_TICK
  } cmd_kind_t;

  // Classified item passed from front to back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        key_v6;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_WRITE,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic        enable;
    logic [31:0] error_limit;
    logic [7:0]  block_periods;
    logic        shutdown_mode;
  } cfg_t;
endpackage

// File: src/ecsb_front.sv
// Front end: classifies input items and queues commands for the back end.
module ecsb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          op,
  input  logic [63:0]         addr_high,
  input  logic [63:0]         addr_low,
  input  logic                addr_is_v6,
  input  logic                is_tls,
  input  logic [31:0]         txn_err_class,
  input  logic [63:0]         txn_err_code,
  input  logic [31:0]         ssn_err_class,
  input  logic [63:0]         ssn_err_code,
  input  logic                enable,
  output logic                cmd_valid,
  output ecsb_pkg::cmd_t      cmd,
  input  logic                cmd_take
);
  localparam int PtrW = $clog2(ecsb_pkg::QDepth);
  ecsb_pkg::cmd_t q [ecsb_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;
  ecsb_pkg::cmd_t  c;
  logic            match;
  logic            do_push;

  always_comb begin
    match = (txn_err_class == 32'd2 && txn_err_code == 64'd8) ||
            (ssn_err_class == 32'd1 && ssn_err_code == 64'd11);
    c.key_v6   = addr_is_v6;
    c.key_high = addr_is_v6 ? addr_high : 64'd0;
    c.key_low  = addr_is_v6 ? addr_low : {32'd0, addr_low[31:0]};
    case (op)
      ecsb_pkg::OpStart: c.kind = (enable && is_tls) ? ecsb_pkg::CMD_START : ecsb_pkg::CMD_NOP;
      ecsb_pkg::OpClose: c.kind = (enable && match) ? ecsb_pkg::CMD_CLOSE : ecsb_pkg::CMD_NOP;
      ecsb_pkg::OpTick:  c.kind = ecsb_pkg::CMD_TICK;
      default:           c.kind = ecsb_pkg::CMD_NOP;
    endcase
  end

  assign full      = (fill == (PtrW+1)'(ecsb_pkg::QDepth));
  assign do_push   = push && !full;
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (cmd_take) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PtrW+1)'(do_push) - (PtrW+1)'(cmd_take);
    end
  end
endmodule

// File: src/ecsb_back.sv
// Back end: table search, update and sweep, with a one-entry result register.
module ecsb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  ecsb_pkg::cmd_t cmd,
  output logic           cmd_take,
  input  ecsb_pkg::cfg_t cfg,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     action,
  output logic [31:0]    error_count,
  output logic           table_full,
  output logic [31:0]    blocks_total,
  output logic           busy
);
  localparam int IW = ecsb_pkg::IdxW;
  localparam int NE = ecsb_pkg::TableEntries;

  // Key and data memories; valid bits in flops.
  logic [128:0] key_mem [NE];
  logic [31:0]  cnt_mem [NE];
  logic [7:0]   per_mem [NE];
  logic [NE-1:0] valid;

  ecsb_pkg::back_state_t state, state_next;
  logic [IW-1:0] idx;
  logic [ecsb_pkg::CntW-1:0] scan;
  logic [IW-1:0] free_idx;
  logic          free_found;
  logic          hit;
  logic [IW-1:0] hit_idx;
  ecsb_pkg::cmd_t cur;
  logic [128:0]  key_rd;
  logic [31:0]   cnt_rd;
  logic [7:0]    per_rd;
  logic [31:0]   block_counter;
  logic          out_full;

  logic [IW-1:0] rd_addr;
  logic          key_we, data_we;
  logic [IW-1:0] wr_addr;
  logic [31:0]   cnt_wd;
  logic [7:0]    per_wd;
  logic [31:0]   cnt_inc;

  assign empty = !out_full;
  assign busy  = (state != ecsb_pkg::ST_IDLE);
  assign blocks_total = block_counter;
  assign cnt_inc = (cnt_rd == 32'hFFFF_FFFF) ? cnt_rd : cnt_rd + 32'd1;

  always_ff @(posedge clk) begin
    key_rd <= key_mem[rd_addr];
    cnt_rd <= cnt_mem[rd_addr];
    per_rd <= per_mem[rd_addr];
    if (key_we) key_mem[wr_addr] <= {cur.key_v6, cur.key_high, cur.key_low};
    if (data_we) begin
      cnt_mem[wr_addr] <= cnt_wd;
      per_mem[wr_addr] <= per_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ecsb_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    rd_addr  = idx;
    key_we   = 1'b0;
    data_we  = 1'b0;
    wr_addr  = idx;
    cnt_wd   = 32'd1;
    per_wd   = 8'd0;
    case (state)
      ecsb_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (cmd_valid && !out_full) begin
          cmd_take = 1'b1;
          case (cmd.kind)
            ecsb_pkg::CMD_START, ecsb_pkg::CMD_CLOSE: state_next = ecsb_pkg::ST_SEARCH;
            ecsb_pkg::CMD_TICK: state_next = ecsb_pkg::ST_SWEEP_RD;
            default: state_next = ecsb_pkg::ST_DONE;
          endcase
        end
      end
      ecsb_pkg::ST_SEARCH: begin
        // key_rd holds entry idx-1 data read at previous cycle
        if (scan != '0 && valid[hit_idx] &&
            key_rd == {cur.key_v6, cur.key_high, cur.key_low}) begin
          state_next = ecsb_pkg::ST_READ;
          rd_addr = hit_idx;
        end else if (scan == ecsb_pkg::CntW'(NE)) begin
          state_next = ecsb_pkg::ST_WRITE;
        end
      end
      ecsb_pkg::ST_READ: begin
        // keep the hit entry's data on the read port
        rd_addr = hit_idx;
        state_next = ecsb_pkg::ST_WRITE;
      end
      ecsb_pkg::ST_WRITE: begin
        state_next = ecsb_pkg::ST_DONE;
        if (cur.kind == ecsb_pkg::CMD_CLOSE) begin
          if (hit) begin
            data_we = 1'b1;
            wr_addr = hit_idx;
            cnt_wd  = cnt_inc;
            per_wd  = per_rd;
          end else if (free_found) begin
            key_we  = 1'b1;
            data_we = 1'b1;
            wr_addr = free_idx;
          end
        end
      end
      ecsb_pkg::ST_SWEEP_RD: state_next = ecsb_pkg::ST_SWEEP_WR;
      ecsb_pkg::ST_SWEEP_WR: begin
        wr_addr = idx;
        if (valid[idx] && !(cnt_rd <= cfg.error_limit || per_rd >= cfg.block_periods)) begin
          data_we = 1'b1;
          cnt_wd  = cnt_rd;
          per_wd  = per_rd + 8'd1;
        end
        if (idx == IW'(NE - 1)) state_next = ecsb_pkg::ST_DONE;
        else begin
          rd_addr = idx + 1'b1;
          state_next = ecsb_pkg::ST_SWEEP_WR;
        end
      end
      ecsb_pkg::ST_DONE: state_next = ecsb_pkg::ST_IDLE;
      default: state_next = ecsb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      block_counter <= '0;
      out_full <= 1'b0;
      idx <= '0;
      scan <= '0;
      hit <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      case (state)
        ecsb_pkg::ST_IDLE: begin
          if (cmd_take) begin
            cur <= cmd;
            idx <= '0;
            scan <= '0;
            hit <= 1'b0;
            free_found <= 1'b0;
            action <= ecsb_pkg::ActPass;
            error_count <= 32'd0;
            table_full <= 1'b0;
          end
        end
        ecsb_pkg::ST_SEARCH: begin
          // hit_idx tracks the entry whose key is now in key_rd
          if (scan != '0 && valid[hit_idx] &&
              key_rd == {cur.key_v6, cur.key_high, cur.key_low}) begin
            hit <= 1'b1;
          end else begin
            if (scan != '0 && !valid[hit_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= hit_idx;
            end
            if (scan != ecsb_pkg::CntW'(NE)) begin
              hit_idx <= idx;
              idx <= idx + 1'b1;
              scan <= scan + 1'b1;
            end
          end
        end
        ecsb_pkg::ST_WRITE: begin
          if (cur.kind == ecsb_pkg::CMD_START) begin
            error_count <= hit ? cnt_rd : 32'd0;
            if (hit && cnt_rd > cfg.error_limit)
              action <= cfg.shutdown_mode ? ecsb_pkg::ActShut : ecsb_pkg::ActDown;
          end else if (hit) begin
            error_count <= cnt_inc;
            if (cnt_inc > cfg.error_limit) action <= ecsb_pkg::ActShut;
          end else if (free_found) begin
            valid[free_idx] <= 1'b1;
            error_count <= 32'd1;
            if (32'd1 > cfg.error_limit) action <= ecsb_pkg::ActShut;
          end else begin
            table_full <= 1'b1;
          end
        end
        ecsb_pkg::ST_SWEEP_WR: begin
          if (valid[idx]) begin
            if (cnt_rd <= cfg.error_limit || per_rd >= cfg.block_periods)
              valid[idx] <= 1'b0;
            else if (per_rd == 8'd0 && block_counter != 32'hFFFF_FFFF)
              block_counter <= block_counter + 32'd1;
          end
          idx <= idx + 1'b1;
        end
        ecsb_pkg::ST_DONE: out_full <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// File: src/error_count_source_blocklist.sv
// Top level of the error-count source blocklist.
//  channel | direction | handshake          | payload
//  input   | in        | push / full        | op, addr_*, is_tls, txn_*, ssn_*
//  result  | out       | pop / empty        | action, error_count, table_full, blocks_total
//  config  | in        | psel/penable/pwrite| paddr, pwdata, prdata, pready
// A start or close item searches the table entry by entry and is then resolved in
// the write state; a tick sweeps all entries, one per cycle through the memory port.
// The back end works one item at a time; a two-item command queue lets input
// be taken while a result waits. rst is synchronous and clears control state.
// A result holds until popped; the back end stalls with a full result register.
module error_count_source_blocklist (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic        addr_is_v6,
  input  logic        is_tls,
  input  logic [31:0] txn_err_class,
  input  logic [63:0] txn_err_code,
  input  logic [31:0] ssn_err_class,
  input  logic [63:0] ssn_err_code,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  action,
  output logic [31:0] error_count,
  output logic        table_full,
  output logic [31:0] blocks_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
`include "assert_macros.svh"

  ecsb_pkg::cfg_t cfg;
  logic           cmd_valid;
  ecsb_pkg::cmd_t cmd;
  logic           cmd_take;
  logic           busy;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Configuration registers, word aligned.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b1;
      cfg.error_limit   <= 32'd1000;
      cfg.block_periods <= 8'd4;
      cfg.shutdown_mode <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        ecsb_pkg::RegEnable:  cfg.enable        <= pwdata[0];
        ecsb_pkg::RegLimit:   cfg.error_limit   <= pwdata;
        ecsb_pkg::RegPeriods: cfg.block_periods <= pwdata[7:0];
        ecsb_pkg::RegMode:    cfg.shutdown_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ecsb_pkg::RegEnable:  prdata = {31'd0, cfg.enable};
      ecsb_pkg::RegLimit:   prdata = cfg.error_limit;
      ecsb_pkg::RegPeriods: prdata = {24'd0, cfg.block_periods};
      ecsb_pkg::RegMode:    prdata = {31'd0, cfg.shutdown_mode};
      default:              prdata = 32'd0;
    endcase
  end

  ecsb_front u_front (
    .clk, .rst, .push, .full, .op, .addr_high, .addr_low, .addr_is_v6, .is_tls,
    .txn_err_class, .txn_err_code, .ssn_err_class, .ssn_err_code,
    .enable(cfg.enable), .cmd_valid, .cmd, .cmd_take
  );

  ecsb_back u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .cfg, .empty, .pop,
    .action, .error_count, .table_full, .blocks_total, .busy
  );

  // Commands are only taken by an idle back end with room for the result.
  `ASSERT_IMPL(a_take_idle, clk, rst, cmd_take, !busy && empty && cmd_valid)
  // A dropped insert never asks for action.
  `ASSERT_IMPL(a_full_pass, clk, rst, !empty && table_full, action == ecsb_pkg::ActPass)
  // The block counter never moves backwards.
  `ASSERT_IMPL(a_blocks_mono, clk, rst, 1'b1 ##1 1'b1, blocks_total >= $past(blocks_total))
endmodule
